FILE: design/npfl_pkg.sv
// Shared types and constants for the node pool free list allocator.
`default_nettype none

package npfl_pkg;

	// Default number of link memory entries; the active slot count never exceeds 256.
	localparam int POOL_DEPTH_DEF = 256;
	localparam int NODE_SLOTS_MAX = 256;

	localparam int CMD_W      = 2;
	localparam int INDEX_W    = 8;
	localparam int ADDR_W     = 32;
	localparam int STRIDE_W   = 16;
	localparam int POOL_W     = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [ADDR_W-1:0]   BASE_ADDR_RST   = 32'd0;
	localparam logic [STRIDE_W-1:0] SLOT_STRIDE_RST = 16'd16;
	localparam logic [POOL_W-1:0]   POOL_SIZE_RST   = 9'd256;

	typedef enum logic [CMD_W-1:0] {
		CMD_INIT    = 2'd0,
		CMD_ACQUIRE = 2'd1,
		CMD_RELEASE = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_ADDR   = 2'd0,
		CFG_SLOT_STRIDE = 2'd1,
		CFG_POOL_SIZE   = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_ACQ  = 2'd1,
		ST_INIT = 2'd2
	} state_t;

endpackage

`default_nettype wire

FILE: design/node_pool_free_list.sv
// Node pool allocator: a LIFO free list of node slots kept in one link memory.
// Release, unknown commands and acquires on an empty list load the result register from
// the input beat; a successful acquire passes the pop state first, and init the sweep of n
// links, where n is pool_size limited to 256 and to the link memory depth (one per cycle).
// Throughput: one release per cycle while out_ready holds; no beat is taken in a pop or sweep.
// Reset: registers take their reset values and the list is empty; the link memory is kept.
`default_nettype none

module node_pool_free_list #(
	parameter int POOL_DEPTH = npfl_pkg::POOL_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	input  wire logic                              cfg_we,
	input  wire logic [npfl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [npfl_pkg::CFG_DATA_W-1:0]   cfg_wdata,

	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [npfl_pkg::CMD_W-1:0]        command,
	input  wire logic [npfl_pkg::INDEX_W-1:0]      node_index,

	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   ok,
	output logic      [npfl_pkg::INDEX_W-1:0]      granted_index,
	output logic      [npfl_pkg::ADDR_W-1:0]       data_address,
	output logic                                   list_empty
);

	// Only the first 256 entries can ever be named by an 8-bit node index, so the link
	// memory stops there even for a larger pool depth.
	localparam int LINK_DEPTH = (POOL_DEPTH < npfl_pkg::NODE_SLOTS_MAX) ?
		POOL_DEPTH : npfl_pkg::NODE_SLOTS_MAX;
	localparam int AW = $clog2(LINK_DEPTH);
	// A link holds a nil flag on top of a node index.
	localparam int LW = AW + 1;
	localparam logic [npfl_pkg::POOL_W-1:0] SLOT_CAP = npfl_pkg::POOL_W'(LINK_DEPTH);
	localparam logic [LW-1:0] LINK_NIL = {1'b1, {AW{1'b0}}};

	// Configuration registers.
	logic [npfl_pkg::ADDR_W-1:0]   base_addr_q;
	logic [npfl_pkg::STRIDE_W-1:0] slot_stride_q;
	logic [npfl_pkg::POOL_W-1:0]   pool_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_addr_q   <= npfl_pkg::BASE_ADDR_RST;
			slot_stride_q <= npfl_pkg::SLOT_STRIDE_RST;
			pool_size_q   <= npfl_pkg::POOL_SIZE_RST;
		end else if (cfg_we) begin
			unique case (npfl_pkg::cfg_reg_t'(cfg_index))
				npfl_pkg::CFG_BASE_ADDR: begin
					base_addr_q <= cfg_wdata;
				end
				npfl_pkg::CFG_SLOT_STRIDE: begin
					slot_stride_q <= cfg_wdata[npfl_pkg::STRIDE_W-1:0];
				end
				npfl_pkg::CFG_POOL_SIZE: begin
					pool_size_q <= cfg_wdata[npfl_pkg::POOL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Number of slots in use: pool_size limited to what the link memory holds.
	logic [npfl_pkg::POOL_W-1:0] slot_count;
	assign slot_count = (pool_size_q > SLOT_CAP) ? SLOT_CAP : pool_size_q;

	// Control and head state.
	npfl_pkg::state_t state_q, state_d;
	logic [LW-1:0] head_q, head_d;
	logic          head_we;
	logic [npfl_pkg::POOL_W-1:0] init_q, init_next;
	logic          init_last;
	logic          head_nil;
	logic [AW-1:0] head_idx;

	assign head_nil  = head_q[AW];
	assign head_idx  = head_q[AW-1:0];
	assign init_next = init_q + npfl_pkg::POOL_W'(1);
	assign init_last = (init_next >= slot_count);

	// Link memory. The read port always looks at the current head, so the popped node's
	// link is ready in the cycle after an acquire beat. Only one state writes per cycle, and
	// the read that an acquire uses is never taken at an edge that writes, so no bypass.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [LW-1:0] ram_wdata;
	logic [LW-1:0] ram_rdata;

	npfl_ram #(
		.WIDTH (LW),
		.DEPTH (LINK_DEPTH)
	) u_links (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (head_idx),
		.rdata (ram_rdata)
	);

	// Input side: a new beat is taken only in idle and only when the result register is
	// free or is being drained in the same cycle.
	logic out_valid_q;
	logic accept;
	npfl_pkg::cmd_t cmd;

	assign in_ready = (state_q == npfl_pkg::ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign cmd      = npfl_pkg::cmd_t'(command);

	logic release_ok;
	assign release_ok = ({1'b0, node_index} < slot_count);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			npfl_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (cmd)
						npfl_pkg::CMD_INIT: begin
							if (slot_count != '0) begin
								state_d = npfl_pkg::ST_INIT;
							end
						end
						npfl_pkg::CMD_ACQUIRE: begin
							if (!head_nil) begin
								state_d = npfl_pkg::ST_ACQ;
							end
						end
						default: begin
						end
					endcase
				end
			end
			npfl_pkg::ST_ACQ: begin
				state_d = npfl_pkg::ST_IDLE;
			end
			npfl_pkg::ST_INIT: begin
				if (init_last) begin
					state_d = npfl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = npfl_pkg::ST_IDLE;
			end
		endcase
	end

	// Datapath control and result formation.
	logic                          res_load;
	logic                          res_ok;
	logic [npfl_pkg::INDEX_W-1:0]  res_granted;
	logic [npfl_pkg::ADDR_W-1:0]   res_addr;
	logic                          res_empty;
	logic [npfl_pkg::INDEX_W-1:0]  pop_index;
	logic [npfl_pkg::STRIDE_W+npfl_pkg::INDEX_W-1:0] pop_offset;

	assign pop_index  = npfl_pkg::INDEX_W'(head_idx);
	assign pop_offset = slot_stride_q * pop_index;

	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = head_idx;
		ram_wdata   = LINK_NIL;
		head_we     = 1'b0;
		head_d      = head_q;
		res_load    = 1'b0;
		res_ok      = 1'b0;
		res_granted = '0;
		res_addr    = '0;
		res_empty   = head_nil;
		unique case (state_q)
			npfl_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (cmd)
						npfl_pkg::CMD_INIT: begin
							// An empty pool answers at once; otherwise the sweep answers.
							if (slot_count == '0) begin
								head_we   = 1'b1;
								head_d    = LINK_NIL;
								res_load  = 1'b1;
								res_ok    = 1'b1;
								res_empty = 1'b1;
							end
						end
						npfl_pkg::CMD_ACQUIRE: begin
							if (head_nil) begin
								res_load  = 1'b1;
								res_empty = 1'b1;
							end
						end
						npfl_pkg::CMD_RELEASE: begin
							res_load = 1'b1;
							if (release_ok) begin
								ram_we    = 1'b1;
								ram_waddr = node_index[AW-1:0];
								ram_wdata = head_q;
								head_we   = 1'b1;
								head_d    = {1'b0, node_index[AW-1:0]};
								res_ok    = 1'b1;
								res_empty = 1'b0;
							end
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			npfl_pkg::ST_ACQ: begin
				// Pop: the head's link becomes the new head and the popped link goes nil.
				ram_we      = 1'b1;
				ram_waddr   = head_idx;
				ram_wdata   = LINK_NIL;
				head_we     = 1'b1;
				head_d      = ram_rdata;
				res_load    = 1'b1;
				res_ok      = 1'b1;
				res_granted = pop_index;
				res_addr    = base_addr_q + npfl_pkg::ADDR_W'(pop_offset);
				res_empty   = ram_rdata[AW];
			end
			npfl_pkg::ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = init_q[AW-1:0];
				ram_wdata = init_last ? LINK_NIL : {1'b0, init_next[AW-1:0]};
				if (init_last) begin
					head_we   = 1'b1;
					head_d    = '0;
					res_load  = 1'b1;
					res_ok    = 1'b1;
					res_empty = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= npfl_pkg::ST_IDLE;
			head_q  <= LINK_NIL;
			init_q  <= '0;
		end else begin
			state_q <= state_d;
			if (head_we) begin
				head_q <= head_d;
			end
			if (state_q == npfl_pkg::ST_INIT) begin
				init_q <= init_next;
			end else begin
				init_q <= '0;
			end
		end
	end

	// Output register: holds one result beat until it is taken.
	logic                         ok_q;
	logic [npfl_pkg::INDEX_W-1:0] granted_q;
	logic [npfl_pkg::ADDR_W-1:0]  addr_q;
	logic                         empty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			ok_q      <= res_ok;
			granted_q <= res_granted;
			addr_q    <= res_addr;
			empty_q   <= res_empty;
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = ok_q;
	assign granted_index = granted_q;
	assign data_address  = addr_q;
	assign list_empty    = empty_q;

	// A new result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while holding a beat");

	// A pop only starts from a non-empty list, and the head is not disturbed meanwhile.
	a_pop_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == npfl_pkg::ST_ACQ) |-> (!head_nil && $stable(head_q)))
		else $error("pop entered with an empty list or a moving head");

	// The init sweep stays inside the active slots.
	a_init_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == npfl_pkg::ST_INIT) |-> (init_q < slot_count))
		else $error("init sweep ran past the slot count");

	// A completed init leaves slot zero at the head.
	a_init_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == npfl_pkg::ST_INIT && init_last) |=> (head_q == '0))
		else $error("init did not leave slot zero at the head");

endmodule

`default_nettype wire

FILE: design/npfl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module npfl_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire
